### design/multi_channel_event_timer_top_macros.svh
// Assertion macros shared by the timer design.
`ifndef MULTI_CHANNEL_EVENT_TIMER_TOP_MACROS_SVH
`define MULTI_CHANNEL_EVENT_TIMER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MCET_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("timer assertion failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define MCET_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("timer assertion failed one cycle later");

`endif

### design/mcet_pkg.sv
`default_nettype none

package mcet_pkg;

   localparam int SLOTS = 16;
   localparam int IDX_W = $clog2(SLOTS);
   localparam int QUEUE_DEPTH = 2;
   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [63:0] NS_PER_SECOND = 64'd1000000000;

   localparam logic [2:0] FUNC_TICK    = 3'd0;
   localparam logic [2:0] FUNC_ADD     = 3'd1;
   localparam logic [2:0] FUNC_ENABLE  = 3'd2;
   localparam logic [2:0] FUNC_DISABLE = 3'd3;
   localparam logic [2:0] FUNC_REMOVE  = 3'd4;

   localparam logic [1:0] KIND_FIRE = 2'd0;
   localparam logic [1:0] KIND_WAKE = 2'd1;
   localparam logic [1:0] KIND_ACK  = 2'd2;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_FULL    = 2'd1;
   localparam logic [1:0] STATUS_NOT_OCC = 2'd2;

   typedef enum logic [2:0] {
      OP_TICK,
      OP_ADD,
      OP_ENABLE,
      OP_DISABLE,
      OP_REMOVE,
      OP_NOP
   } op_type;

   typedef struct packed {
      logic [2:0]  func;
      logic [3:0]  slot;
      logic [63:0] now_ns;
      logic [63:0] interval_ns;
      logic        oneshot;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [3:0]  slot_id;
      logic [63:0] wake_ns;
      logic [1:0]  status;
      logic        last;
   } rsp_type;

   typedef struct packed {
      op_type      op;
      logic [3:0]  slot;
      logic        slot_ok;
      logic [63:0] now_ns;
      logic [63:0] interval_ns;
      logic        oneshot;
   } cmd_type;

endpackage

`default_nettype wire

### design/mcet_front.sv
`default_nettype none

module mcet_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire mcet_pkg::req_type req_data,
   input  wire logic             pop,
   output logic                  cmd_valid,
   output mcet_pkg::cmd_type     cmd
);
   import mcet_pkg::*;

   cmd_type           q_mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff;
   logic [PTR_W-1:0]  rd_ptr_ff;
   logic [CNT_W-1:0]  count_ff;
   logic              push;
   cmd_type           decoded;

   always_comb begin
      decoded.slot = req_data.slot;
      decoded.slot_ok = (32'(req_data.slot) < SLOTS);
      decoded.now_ns = req_data.now_ns;
      decoded.interval_ns = req_data.interval_ns;
      decoded.oneshot = req_data.oneshot;
      unique case (req_data.func)
         FUNC_TICK:    decoded.op = OP_TICK;
         FUNC_ADD:     decoded.op = OP_ADD;
         FUNC_ENABLE:  decoded.op = OP_ENABLE;
         FUNC_DISABLE: decoded.op = OP_DISABLE;
         FUNC_REMOVE:  decoded.op = OP_REMOVE;
         default:      decoded.op = OP_NOP;
      endcase
   end

   assign busy = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign push = start && !busy;
   assign cmd_valid = (count_ff != '0);
   assign cmd = q_mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

`default_nettype wire

### design/mcet_back.sv
`default_nettype none

module mcet_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             cmd_valid,
   input  wire mcet_pkg::cmd_type cmd,
   output logic                  pop,
   output logic                  rsp_valid,
   output mcet_pkg::rsp_type     rsp_data
);
   import mcet_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_TICK,
      ST_DRAIN,
      ST_WAKE
   } state_type;

   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SLOTS - 1);

   state_type         state_ff, state_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [63:0]       now_ff, now_in;
   logic [SLOTS-1:0]  occ_ff, occ_in;
   logic [SLOTS-1:0]  en_ff, en_in;
   logic [SLOTS-1:0]  os_ff, os_in;
   logic              b_valid_ff, b_valid_in;
   logic              b_en_ff, b_en_in;
   logic [63:0]       b_due_ff, b_due_in;
   logic              have_ff, have_in;
   logic [63:0]       best_ff, best_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic [63:0]       period_mem [SLOTS];
   logic [63:0]       due_mem [SLOTS];

   logic [IDX_W-1:0]  rd_idx;
   logic [63:0]       rd_period;
   logic [63:0]       rd_due;
   logic [IDX_W-1:0]  cmd_idx;
   logic              free_found;
   logic [IDX_W-1:0]  free_idx;
   logic              pass;
   logic [63:0]       sum;
   logic              wr_due_en;
   logic              wr_period_en;
   logic [IDX_W-1:0]  wr_idx;
   logic [63:0]       wr_due;

   assign cmd_idx = cmd.slot[IDX_W-1:0];
   assign rd_idx = (state_ff == ST_TICK) ? idx_ff : cmd_idx;
   assign rd_period = period_mem[rd_idx];
   assign rd_due = due_mem[rd_idx];

   always_comb begin
      free_found = 1'b0;
      free_idx = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!occ_ff[i]) begin
            free_found = 1'b1;
            free_idx = IDX_W'(i);
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      now_in = now_ff;
      occ_in = occ_ff;
      en_in = en_ff;
      os_in = os_ff;
      b_valid_in = 1'b0;
      b_en_in = b_en_ff;
      b_due_in = b_due_ff;
      have_in = have_ff;
      best_in = best_ff;
      rsp_valid_in = 1'b0;
      rsp_in = '0;
      pop = 1'b0;
      pass = 1'b0;
      sum = '0;
      wr_due_en = 1'b0;
      wr_period_en = 1'b0;
      wr_idx = rd_idx;
      wr_due = '0;

      if (b_valid_ff && b_en_ff && (!have_ff || (b_due_ff < best_ff))) begin
         have_in = 1'b1;
         best_in = b_due_ff;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               pop = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_in.kind = KIND_ACK;
               rsp_in.last = 1'b1;
               unique case (cmd.op) inside
                  OP_TICK: begin
                     rsp_valid_in = 1'b0;
                     rsp_in = '0;
                     now_in = cmd.now_ns;
                     idx_in = '0;
                     have_in = 1'b0;
                     state_in = ST_TICK;
                  end
                  OP_ADD: begin
                     if (free_found) begin
                        occ_in[free_idx] = 1'b1;
                        en_in[free_idx] = 1'b0;
                        os_in[free_idx] = cmd.oneshot;
                        wr_idx = free_idx;
                        wr_period_en = 1'b1;
                        wr_due_en = 1'b1;
                        wr_due = cmd.now_ns + cmd.interval_ns;
                        rsp_in.slot_id = 4'(free_idx);
                     end else begin
                        rsp_in.status = STATUS_FULL;
                     end
                  end
                  OP_ENABLE, OP_DISABLE, OP_REMOVE: begin
                     rsp_in.slot_id = cmd.slot;
                     if (!cmd.slot_ok || !occ_ff[cmd_idx]) begin
                        rsp_in.status = STATUS_NOT_OCC;
                     end else if (cmd.op == OP_ENABLE) begin
                        en_in[cmd_idx] = 1'b1;
                        wr_idx = cmd_idx;
                        wr_due_en = 1'b1;
                        wr_due = cmd.now_ns + rd_period;
                     end else if (cmd.op == OP_DISABLE) begin
                        en_in[cmd_idx] = 1'b0;
                     end else begin
                        occ_in[cmd_idx] = 1'b0;
                        en_in[cmd_idx] = 1'b0;
                        os_in[cmd_idx] = 1'b0;
                     end
                  end
                  OP_NOP: begin
                     rsp_in.status = STATUS_OK;
                  end
               endcase
            end
         end
         ST_TICK: begin
            pass = occ_ff[idx_ff] && (rd_due < now_ff);
            sum = now_ff + rd_period;
            if (pass) begin
               wr_idx = idx_ff;
               wr_due_en = 1'b1;
               wr_due = sum;
               if (en_ff[idx_ff]) begin
                  rsp_valid_in = 1'b1;
                  rsp_in.kind = KIND_FIRE;
                  rsp_in.slot_id = 4'(idx_ff);
                  if (os_ff[idx_ff]) begin
                     en_in[idx_ff] = 1'b0;
                  end
               end
            end
            b_valid_in = 1'b1;
            b_due_in = pass ? sum : rd_due;
            b_en_in = occ_ff[idx_ff] && en_ff[idx_ff] && !(pass && os_ff[idx_ff]);
            if (idx_ff == IDX_LAST) begin
               state_in = ST_DRAIN;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            state_in = ST_WAKE;
         end
         ST_WAKE: begin
            rsp_valid_in = 1'b1;
            rsp_in.kind = KIND_WAKE;
            rsp_in.wake_ns = have_ff ? best_ff : (now_ff + NS_PER_SECOND);
            rsp_in.last = 1'b1;
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff <= '0;
         occ_ff <= '0;
         en_ff <= '0;
         os_ff <= '0;
         b_valid_ff <= 1'b0;
         have_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in;
         occ_ff <= occ_in;
         en_ff <= en_in;
         os_ff <= os_in;
         b_valid_ff <= b_valid_in;
         have_ff <= have_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      now_ff <= now_in;
      b_en_ff <= b_en_in;
      b_due_ff <= b_due_in;
      best_ff <= best_in;
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (wr_period_en) begin
         period_mem[wr_idx] <= cmd.interval_ns;
      end
      if (wr_due_en) begin
         due_mem[wr_idx] <= wr_due;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

### design/multi_channel_event_timer_top.sv
// Commands: an accepted start is queued and the back end registers its acknowledgment;
// one per cycle sustained while no tick holds the back end. Tick: the back end visits
// all 16 slots in turn, settles the minimum in ST_DRAIN, then sends the wake beat.
// A two-entry queue ahead of the back end sets when busy rises; results cannot stall.
// Synchronous active-high reset empties the queue and clears every slot's flags.
`default_nettype none

`include "multi_channel_event_timer_top_macros.svh"

module multi_channel_event_timer_top (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire mcet_pkg::req_type req_data,
   output logic                  rsp_valid,
   output mcet_pkg::rsp_type     rsp_data
);
   import mcet_pkg::*;

   logic    cmd_valid;
   logic    pop;
   cmd_type cmd;

   mcet_front u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .pop       (pop),
      .cmd_valid (cmd_valid),
      .cmd       (cmd)
   );

   mcet_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   `MCET_ASSERT_SAME(a_pop_needs_entry, clock, reset, pop, cmd_valid)
   `MCET_ASSERT_NEXT(a_accept_fills_queue, clock, reset, start && !busy, cmd_valid)
   `MCET_ASSERT_SAME(a_only_fire_not_last, clock, reset, rsp_valid && !rsp_data.last, rsp_data.kind == KIND_FIRE)

endmodule

`default_nettype wire
